// ===== rtl/plfe_pkg.sv =====
// Shared types, constants and helpers for the Playfair digraph encryptor.
// No dependencies; every other file of the block imports this package.
package plfe_pkg;

    localparam int LETTER_W = 5;
    localparam int SQ_DIM   = 5;
    localparam int ROW_W    = SQ_DIM * LETTER_W;
    localparam int POS_W    = 3;
    localparam int IDX_W    = 3;

    typedef logic [LETTER_W-1:0]            letter_t;
    typedef logic [ROW_W-1:0]               row_t;
    typedef logic [SQ_DIM-1:0][ROW_W-1:0]   square_t;
    typedef logic [POS_W-1:0]               pos_t;
    typedef logic [IDX_W-1:0]               reg_index_t;

    localparam letter_t CODE_SPACE = 5'd26;
    localparam letter_t CODE_I     = 5'd8;
    localparam letter_t CODE_J     = 5'd9;

    // Register indexes on the configuration port.
    localparam reg_index_t REG_ROW_0     = 3'd0;
    localparam reg_index_t REG_ROW_1     = 3'd1;
    localparam reg_index_t REG_ROW_2     = 3'd2;
    localparam reg_index_t REG_ROW_3     = 3'd3;
    localparam reg_index_t REG_ROW_4     = 3'd4;
    localparam reg_index_t REG_SEPARATOR = 3'd5;
    localparam reg_index_t REG_SPACE     = 3'd6;

    localparam row_t    RST_ROW_0     = 25'd4294688;
    localparam row_t    RST_ROW_1     = 25'd10755269;
    localparam row_t    RST_ROW_2     = 25'd16201099;
    localparam row_t    RST_ROW_3     = 25'd21613104;
    localparam row_t    RST_ROW_4     = 25'd27025109;
    localparam letter_t RST_SEPARATOR = 5'd23;
    localparam letter_t RST_SPACE     = 5'd25;

    // The pair currently being sent, and where in it the next beat stands.
    typedef struct packed {
        logic    valid;
        letter_t first;
        letter_t second;
        logic    take_second;
        logic    final_beat;
    } pair_job_t;

    function automatic letter_t fold_letter(letter_t v);
        return (v == CODE_J) ? CODE_I : v;
    endfunction

endpackage

// ===== rtl/plfe_intf.sv =====
// Channel interfaces for the Playfair digraph encryptor: plaintext input,
// cipher output and the configuration write channel. Depends on plfe_pkg.
interface plfe_plain_if;
    import plfe_pkg::*;
    logic    valid;
    logic    ready;
    letter_t plain_letter;
    logic    end_of_text;
    modport source(output valid, output plain_letter, output end_of_text, input ready);
    modport sink(input valid, input plain_letter, input end_of_text, output ready);
endinterface

interface plfe_cipher_if;
    import plfe_pkg::*;
    logic    valid;
    logic    ready;
    letter_t cipher_letter;
    logic    last_of_run;
    modport source(output valid, output cipher_letter, output last_of_run, input ready);
    modport sink(input valid, input cipher_letter, input last_of_run, output ready);
endinterface

interface plfe_cfg_if;
    import plfe_pkg::*;
    logic       valid;
    logic       ready;
    reg_index_t index;
    row_t       data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/plfe_cfg_regs.sv =====
// Configuration registers: the five key square rows and the separator and
// space letters. Depends on plfe_pkg and plfe_cfg_if.
module plfe_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    plfe_cfg_if.sink          cfg,
    output plfe_pkg::square_t square,
    output plfe_pkg::letter_t separator,
    output plfe_pkg::letter_t space_code
);
    import plfe_pkg::*;

    square_t square_reg;
    letter_t separator_reg;
    letter_t space_reg;

    assign cfg.ready  = 1'b1;
    assign square     = square_reg;
    assign separator  = separator_reg;
    assign space_code = space_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg[0] <= RST_ROW_0;
            square_reg[1] <= RST_ROW_1;
            square_reg[2] <= RST_ROW_2;
            square_reg[3] <= RST_ROW_3;
            square_reg[4] <= RST_ROW_4;
            separator_reg <= RST_SEPARATOR;
            space_reg     <= RST_SPACE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_ROW_0:     square_reg[0] <= cfg.data;
                REG_ROW_1:     square_reg[1] <= cfg.data;
                REG_ROW_2:     square_reg[2] <= cfg.data;
                REG_ROW_3:     square_reg[3] <= cfg.data;
                REG_ROW_4:     square_reg[4] <= cfg.data;
                REG_SEPARATOR: separator_reg <= cfg.data[LETTER_W-1:0];
                REG_SPACE:     space_reg     <= cfg.data[LETTER_W-1:0];
                default:       ;
            endcase
        end
    end

endmodule

// ===== rtl/plfe_pair_former.sv =====
// Input stage: folds letters, keeps the waiting first letter and registers
// the one or two pairs an input closes. Depends on plfe_pkg and plfe_plain_if.
module plfe_pair_former (
    input  logic                clk,
    input  logic                rst_n,
    plfe_plain_if.sink          plain_in,
    input  plfe_pkg::letter_t   separator,
    input  plfe_pkg::letter_t   space_code,
    input  logic                advance,
    output plfe_pkg::pair_job_t job
);
    import plfe_pkg::*;

    logic    held_valid_reg, held_valid_next;
    letter_t held_letter_reg, held_letter_next;
    logic    job_valid_reg, job_valid_next;
    logic    two_pairs_reg, two_pairs_next;
    logic    pair_idx_reg, pair_idx_next;
    logic    half_reg, half_next;
    letter_t p0_first_reg, p0_first_next;
    letter_t p0_second_reg, p0_second_next;
    letter_t p1_first_reg, p1_first_next;

    letter_t sep;
    letter_t letter;
    logic    accept;
    logic    load;
    logic    final_beat;

    assign sep        = fold_letter(separator);
    assign letter     = (plain_in.plain_letter >= CODE_SPACE) ? fold_letter(space_code)
                                                             : fold_letter(plain_in.plain_letter);
    assign final_beat = half_reg && (pair_idx_reg || !two_pairs_reg);
    assign plain_in.ready = !job_valid_reg || (advance && final_beat);
    assign accept     = plain_in.valid && plain_in.ready;

    always_comb
    begin
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        load             = 1'b0;
        two_pairs_next   = two_pairs_reg;
        p0_first_next    = p0_first_reg;
        p0_second_next   = p0_second_reg;
        p1_first_next    = p1_first_reg;
        if (accept)
        begin
            if (!held_valid_reg)
            begin
                // First letter of a pair; an end of text pads it at once.
                held_valid_next  = !plain_in.end_of_text;
                held_letter_next = letter;
                load             = plain_in.end_of_text;
                p0_first_next    = letter;
                p0_second_next   = sep;
                two_pairs_next   = 1'b0;
            end
            else if (letter == held_letter_reg)
            begin
                // Doubled letter: the separator closes this pair and the
                // repeat opens the next one.
                load             = 1'b1;
                p0_first_next    = held_letter_reg;
                p0_second_next   = sep;
                p1_first_next    = letter;
                two_pairs_next   = plain_in.end_of_text;
                held_valid_next  = !plain_in.end_of_text;
                held_letter_next = letter;
            end
            else
            begin
                load             = 1'b1;
                p0_first_next    = held_letter_reg;
                p0_second_next   = letter;
                two_pairs_next   = 1'b0;
                held_valid_next  = 1'b0;
            end
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        pair_idx_next  = pair_idx_reg;
        half_next      = half_reg;
        if (advance)
        begin
            if (!half_reg)
            begin
                half_next = 1'b1;
            end
            else if (!final_beat)
            begin
                pair_idx_next = 1'b1;
                half_next     = 1'b0;
            end
            else
            begin
                job_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            job_valid_next = 1'b1;
            pair_idx_next  = 1'b0;
            half_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            job_valid_reg  <= 1'b0;
            two_pairs_reg  <= 1'b0;
            pair_idx_reg   <= 1'b0;
            half_reg       <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            job_valid_reg  <= job_valid_next;
            two_pairs_reg  <= two_pairs_next;
            pair_idx_reg   <= pair_idx_next;
            half_reg       <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_letter_reg <= held_letter_next;
        p0_first_reg    <= p0_first_next;
        p0_second_reg   <= p0_second_next;
        p1_first_reg    <= p1_first_next;
    end

    // The second pair always ends on the separator.
    assign job.valid       = job_valid_reg;
    assign job.first       = pair_idx_reg ? p1_first_reg : p0_first_reg;
    assign job.second      = pair_idx_reg ? fold_letter(separator) : p0_second_reg;
    assign job.take_second = half_reg;
    assign job.final_beat  = final_beat;

endmodule

// ===== rtl/plfe_pair_cipher.sv =====
// Playfair rules for one pair against the key square: locate both letters,
// then apply the row, column or rectangle rule. Depends on plfe_pkg.
module plfe_pair_cipher (
    input  plfe_pkg::square_t square,
    input  plfe_pkg::letter_t first,
    input  plfe_pkg::letter_t second,
    input  logic              take_second,
    output plfe_pkg::letter_t cipher
);
    import plfe_pkg::*;

    function automatic letter_t cell_at(square_t sq, pos_t r, pos_t c);
        row_t row;
        row = sq[r];
        return row[c*LETTER_W +: LETTER_W];
    endfunction

    function automatic pos_t step_pos(pos_t p);
        return (p == pos_t'(SQ_DIM - 1)) ? '0 : pos_t'(p + 1'b1);
    endfunction

    pos_t    row_a, col_a, row_b, col_b;
    letter_t x_letter, y_letter;

    // A letter missing from the square sits at row 0, column 0; when a letter
    // appears more than once, the last match in row-major order wins.
    always_comb
    begin
        row_a = '0;
        col_a = '0;
        row_b = '0;
        col_b = '0;
        for (int r = 0; r < SQ_DIM; r++)
        begin
            for (int c = 0; c < SQ_DIM; c++)
            begin
                if (square[r][c*LETTER_W +: LETTER_W] == first)
                begin
                    row_a = pos_t'(r);
                    col_a = pos_t'(c);
                end
                if (square[r][c*LETTER_W +: LETTER_W] == second)
                begin
                    row_b = pos_t'(r);
                    col_b = pos_t'(c);
                end
            end
        end
    end

    always_comb
    begin
        if (row_a == row_b)
        begin
            x_letter = cell_at(square, row_a, step_pos(col_a));
            y_letter = cell_at(square, row_b, step_pos(col_b));
        end
        else if (col_a == col_b)
        begin
            x_letter = cell_at(square, step_pos(row_a), col_a);
            y_letter = cell_at(square, step_pos(row_b), col_b);
        end
        else
        begin
            x_letter = cell_at(square, row_a, col_b);
            y_letter = cell_at(square, row_b, col_a);
        end
    end

    assign cipher = take_second ? y_letter : x_letter;

endmodule

// ===== rtl/playfair_digraph_encrypt_unit.sv =====
// Top level of the Playfair digraph encryptor: configuration registers, pair
// former, pair cipher and the output register. Depends on plfe_pkg, plfe_intf.
//
// Plaintext symbols go in one beat at a time; each completed pair leaves as two
// cipher letter beats, with last_of_run on the final beat an input caused. The
// result channel carries one letter per cycle while the receiver is ready, from
// a single output register, so the next input is taken only as the final beat
// of the last one moves; an input that only opens a pair holds nothing off. The
// first cipher letter of a pair passes through the pair former's registers and
// then the output register. The key square is five rows of five letter codes,
// column 0 in the low bits; software builds it from the key. There is no
// clearing pass.
module playfair_digraph_encrypt_unit (
    input  logic          clk,
    input  logic          rst_n,
    plfe_plain_if.sink    plain_in,
    plfe_cipher_if.source cipher_out,
    plfe_cfg_if.sink      cfg
);
    import plfe_pkg::*;

    square_t   square;
    letter_t   separator;
    letter_t   space_code;
    pair_job_t job;
    letter_t   cipher;
    logic      advance;
    logic      in_accept;

    logic    out_valid_reg, out_valid_next;
    letter_t out_letter_reg;
    logic    out_last_reg;

    plfe_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .square     (square),
        .separator  (separator),
        .space_code (space_code)
    );

    plfe_pair_former u_pair_former (
        .clk        (clk),
        .rst_n      (rst_n),
        .plain_in   (plain_in),
        .separator  (separator),
        .space_code (space_code),
        .advance    (advance),
        .job        (job)
    );

    plfe_pair_cipher u_pair_cipher (
        .square      (square),
        .first       (job.first),
        .second      (job.second),
        .take_second (job.take_second),
        .cipher      (cipher)
    );

    assign in_accept = plain_in.valid && plain_in.ready;
    assign advance   = job.valid && (!out_valid_reg || cipher_out.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (cipher_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_letter_reg <= cipher;
            out_last_reg   <= job.final_beat;
        end
    end

    assign cipher_out.valid         = out_valid_reg;
    assign cipher_out.cipher_letter = out_letter_reg;
    assign cipher_out.last_of_run   = out_last_reg;

    // A pending pair that cannot move must hold off the next input beat.
    a_no_accept_over_job: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid && !advance |-> !plain_in.ready)
        else $error("input accepted while a pair was still pending");

    // Moving a beat that is not the final one leaves work behind.
    a_job_continues: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !job.final_beat |=> job.valid)
        else $error("pair work lost before its final beat");

    // The final beat drains the job unless a new input arrived with it.
    a_job_drains: assert property (@(posedge clk) disable iff (!rst_n)
        advance && job.final_beat && !in_accept |=> !job.valid)
        else $error("pair work still pending after its final beat");

    // Every moved beat makes the output register valid.
    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> cipher_out.valid)
        else $error("cipher beat moved but output not valid");

endmodule

// ===== verif/playfair_digraph_encrypt_unit_tb.sv =====
// Self-checking testbench for playfair_digraph_encrypt_unit: directed and random
// plaintext under several key squares. Depends on plfe_pkg, plfe_intf and the block.
`timescale 1ns / 100ps

module playfair_digraph_encrypt_unit_tb;
    import plfe_pkg::*;

    localparam reg_index_t REG_UNUSED     = 3'd7;
    localparam letter_t    CODE_TOP       = 5'd31;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         PHASE_ITEMS    = 18;

    typedef struct packed {
        letter_t letter;
        logic    closes;
    } cipher_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    plfe_plain_if  plain_if();
    plfe_cipher_if cipher_if();
    plfe_cfg_if    cfg_if();

    playfair_digraph_encrypt_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .plain_in   (plain_if),
        .cipher_out (cipher_if),
        .cfg        (cfg_if)
    );

    always #10 clk = ~clk;

    // Mirror of the block's registers and pairing state.
    row_t    key_sq [SQ_DIM];
    letter_t sep_code;
    letter_t space_code;
    logic    pair_open;
    letter_t pair_first;

    cipher_beat_t cipher_due [$];
    row_t         plan_sq [SQ_DIM];

    int fail_count  = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;
    int quiet_count = 0;

    function automatic letter_t drop_j(letter_t v);
        letter_t l;
        l = v;
        if (l == CODE_J)
            l = CODE_I;
        return l;
    endfunction

    function automatic letter_t square_at(int r, int c);
        return key_sq[r % SQ_DIM][LETTER_W * (c % SQ_DIM) +: LETTER_W];
    endfunction

    // A letter missing from the square sits at the top-left corner; a repeated
    // one takes its last position in row-major order.
    function automatic void find_letter(input letter_t l, output int r, output int c);
        r = 0;
        c = 0;
        for (int i = 0; i < SQ_DIM; i++)
        begin
            for (int k = 0; k < SQ_DIM; k++)
            begin
                if (square_at(i, k) == l)
                begin
                    r = i;
                    c = k;
                end
            end
        end
    endfunction

    task automatic encipher_pair(input letter_t a, input letter_t b, input logic closes);
        int ra, ca, rb, cb;
        letter_t x, y;
        find_letter(a, ra, ca);
        find_letter(b, rb, cb);
        if (ra == rb)
        begin
            x = square_at(ra, ca + 1);
            y = square_at(rb, cb + 1);
        end
        else if (ca == cb)
        begin
            x = square_at(ra + 1, ca);
            y = square_at(rb + 1, cb);
        end
        else
        begin
            x = square_at(ra, cb);
            y = square_at(rb, ca);
        end
        cipher_due.push_back('{letter: x, closes: 1'b0});
        cipher_due.push_back('{letter: y, closes: closes});
    endtask

    task automatic predict_cipher(input letter_t plain, input logic eot);
        letter_t l, sep, p0, p1;
        bit have_pair, pad;
        sep = drop_j(sep_code);
        l = (plain >= CODE_SPACE) ? drop_j(space_code) : drop_j(plain);
        have_pair = 1'b0;
        if (pair_open)
        begin
            have_pair = 1'b1;
            p0 = pair_first;
            if (l == pair_first)
                p1 = sep;
            else
            begin
                p1 = l;
                pair_open = 1'b0;
            end
        end
        else
        begin
            pair_open = 1'b1;
            pair_first = l;
        end
        pad = eot && pair_open;
        if (have_pair)
            encipher_pair(p0, p1, !pad);
        if (pad)
        begin
            encipher_pair(pair_first, sep, 1'b1);
            pair_open = 1'b0;
        end
    endtask

    task automatic send_letter(input letter_t l, input logic eot);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = gaps_on ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                plain_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        plain_if.valid        <= 1'b1;
        plain_if.plain_letter <= l;
        plain_if.end_of_text  <= eot;
        @(posedge clk);
        while (!plain_if.ready)
            @(posedge clk);
        predict_cipher(l, eot);
        burst_left--;
    endtask

    // '#' stands for code 31, which the block must treat as a space.
    task automatic send_text(input string s);
        byte ch;
        letter_t code;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if (ch == " ")
                code = CODE_SPACE;
            else if (ch == "#")
                code = CODE_TOP;
            else
                code = letter_t'(ch - "a");
            send_letter(code, i == s.len() - 1);
        end
    endtask

    task automatic settle();
        plain_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (cipher_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input row_t data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_ROW_0, REG_ROW_1, REG_ROW_2, REG_ROW_3, REG_ROW_4: key_sq[idx] = data;
            REG_SEPARATOR: sep_code = data[LETTER_W-1:0];
            REG_SPACE:     space_code = data[LETTER_W-1:0];
            default: ;
        endcase
    endtask

    // Letter registers get random upper bits, which the block must drop.
    task automatic load_settings(input letter_t sep, input letter_t spc);
        row_t d;
        write_reg(REG_ROW_0, plan_sq[0]);
        write_reg(REG_ROW_1, plan_sq[1]);
        write_reg(REG_ROW_2, plan_sq[2]);
        write_reg(REG_ROW_3, plan_sq[3]);
        write_reg(REG_ROW_4, plan_sq[4]);
        d = row_t'($urandom);
        d[LETTER_W-1:0] = sep;
        write_reg(REG_SEPARATOR, d);
        d = row_t'($urandom);
        d[LETTER_W-1:0] = spc;
        write_reg(REG_SPACE, d);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Usually a proper square of the 25 letters without j; now and then one
    // with a letter repeated, or rows of raw random codes.
    task automatic plan_random_square();
        letter_t pool [25];
        letter_t tmp;
        int k, j, style;
        k = 0;
        for (int c = 0; c < 26; c++)
        begin
            if (letter_t'(c) != CODE_J)
            begin
                pool[k] = letter_t'(c);
                k++;
            end
        end
        for (int i = 24; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        style = $urandom_range(0, 9);
        if (style == 1)
            pool[$urandom_range(0, 24)] = pool[$urandom_range(0, 24)];
        for (int r = 0; r < SQ_DIM; r++)
        begin
            for (int c = 0; c < SQ_DIM; c++)
                plan_sq[r][LETTER_W * c +: LETTER_W] = pool[SQ_DIM * r + c];
            if (style == 0)
                plan_sq[r] = row_t'($urandom);
        end
    endtask

    function automatic letter_t random_setting_letter();
        if ($urandom_range(0, 4) == 0)
            return ($urandom_range(0, 1) != 0) ? CODE_TOP : letter_t'(0);
        return letter_t'($urandom_range(0, 25));
    endfunction

    // Mostly whole messages that end on end_of_text, weighted towards doubled
    // letters, j, spaces and the separator; the odd beat is raw noise.
    task automatic send_random_message(inout int sent);
        int len, pick;
        letter_t l, prev;
        if ($urandom_range(0, 7) == 0)
        begin
            send_letter(letter_t'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            sent++;
            return;
        end
        len = $urandom_range(1, 9);
        prev = letter_t'($urandom_range(0, 25));
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                l = letter_t'($urandom_range(26, 31));
            else if (pick < 30)
                l = prev;
            else if (pick < 38)
                l = CODE_J;
            else if (pick < 44)
                l = sep_code;
            else
                l = letter_t'($urandom_range(0, 25));
            send_letter(l, i == len - 1);
            prev = l;
            sent++;
        end
    endtask

    task automatic test_default_square();
        // Rectangle, doubled letter closed by the separator, same-row pair.
        send_text("hello");
        // Space and code 31 both become z and double up; j folds to i;
        // same-column pairs, one wrapping from the bottom row to the top.
        send_text(" #jdtyd");
        // A doubled separator shifts right along its row.
        send_text("xxa");
        send_text("z");
        // i followed by j doubles up and the tail is padded: four beats.
        send_text("ij");
    endtask

    task automatic test_register_extremes();
        settle();
        for (int r = 0; r < SQ_DIM; r++)
            plan_sq[r] = '0;
        load_settings(5'd0, 5'd0);
        send_text("e ");
        settle();
        for (int r = 0; r < SQ_DIM; r++)
            plan_sq[r] = '1;
        load_settings(CODE_TOP, CODE_TOP);
        send_text("ff");
        settle();
        plan_sq[0] = RST_ROW_0;
        plan_sq[1] = RST_ROW_1;
        plan_sq[2] = RST_ROW_2;
        plan_sq[3] = RST_ROW_3;
        plan_sq[4] = RST_ROW_4;
        load_settings(CODE_J, CODE_J);
        // An index past the last register must change nothing.
        write_reg(REG_UNUSED, row_t'($urandom));
        cfg_if.valid <= 1'b0;
        @(posedge clk);
        send_text(" i");
    endtask

    task automatic test_random_traffic();
        int sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            plan_random_square();
            load_settings(random_setting_letter(), random_setting_letter());
            // One phase runs flat out on both sides.
            gaps_on   = (phase != 2);
            stalls_on = (phase != 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
                send_random_message(sent);
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Receiver: runs of ready and stall, each chosen at random, with random lengths.
    int  stall_run = 0;
    bit  rx_ready  = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
            cipher_if.ready <= 1'b0;
        else
        begin
            if (stall_run == 0)
            begin
                rx_ready  = !stalls_on || ($urandom_range(0, 2) != 0);
                stall_run = rx_ready ? $urandom_range(1, 10) : $urandom_range(1, 5);
            end
            stall_run--;
            cipher_if.ready <= rx_ready;
        end
    end

    always @(posedge clk)
    begin
        cipher_beat_t due;
        if (rst_n && cipher_if.valid && cipher_if.ready)
        begin
            if (cipher_due.size() == 0)
            begin
                $display("%0t: unexpected cipher beat, letter %0d last %0b", $time,
                         cipher_if.cipher_letter, cipher_if.last_of_run);
                fail_count++;
            end
            else
            begin
                due = cipher_due.pop_front();
                if (cipher_if.cipher_letter !== due.letter)
                begin
                    $display("%0t: cipher_letter mismatch: expected %0d, actual %0d", $time,
                             due.letter, cipher_if.cipher_letter);
                    fail_count++;
                end
                if (cipher_if.last_of_run !== due.closes)
                begin
                    $display("%0t: last_of_run mismatch: expected %0b, actual %0b", $time,
                             due.closes, cipher_if.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if no channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((plain_if.valid && plain_if.ready) || (cipher_if.valid && cipher_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n                 <= 1'b0;
        plain_if.valid        <= 1'b0;
        plain_if.plain_letter <= '0;
        plain_if.end_of_text  <= 1'b0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= REG_ROW_0;
        cfg_if.data           <= '0;
        key_sq[0]  = RST_ROW_0;
        key_sq[1]  = RST_ROW_1;
        key_sq[2]  = RST_ROW_2;
        key_sq[3]  = RST_ROW_3;
        key_sq[4]  = RST_ROW_4;
        sep_code   = RST_SEPARATOR;
        space_code = RST_SPACE;
        pair_open  = 1'b0;
        pair_first = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_default_square();
        test_register_extremes();
        test_random_traffic();
        settle();

        if (fail_count == 0 && cipher_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
